@@ rtl/core/mitchell_image_resampler_assert.svh @@
// assertion macros for the mitchell image resampler
// no dependencies; taken in by the files that check their own logic
`ifndef MITCHELL_IMAGE_RESAMPLER_ASSERT_SVH
`define MITCHELL_IMAGE_RESAMPLER_ASSERT_SVH
`ifndef SYNTH
// condition holds at every edge out of reset
`define MIR_ASSERT_ALW(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define MIR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// consequent holds in the cycle after the antecedent
`define MIR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MIR_ASSERT_ALW(label, clk, rst_n, cond, msg)
`define MIR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MIR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/mir_pkg.sv @@
// shared types and constants of the mitchell image resampler
// no dependencies; used by the channel interfaces and the top level
package mir_pkg;

  localparam int MAX_DIM_DEF   = 256;
  localparam int MAX_RATIO_DEF = 4;

  localparam int DIM_W   = 9;
  localparam int COORD_W = 8;
  localparam int PIX_W   = 8;
  localparam int FAULT_W = 2;

  localparam logic [DIM_W-1:0] SRC_W_RST = 9'd256;
  localparam logic [DIM_W-1:0] SRC_H_RST = 9'd256;
  localparam logic [DIM_W-1:0] DST_W_RST = 9'd64;
  localparam logic [DIM_W-1:0] DST_H_RST = 9'd64;

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_WSUM  = 2'd1,
    FAULT_RATIO = 2'd2
  } fault_e;

endpackage

@@ rtl/core/mir_if.sv @@
// valid/ready channel interfaces of the mitchell image resampler
// depends on mir_pkg for the field widths
interface mir_in_if import mir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [PIX_W-1:0]   pix_red;
  logic [PIX_W-1:0]   pix_green;
  logic [PIX_W-1:0]   pix_blue;
  logic [PIX_W-1:0]   pix_alpha;

  modport source (output valid, opcode, col, row, pix_red, pix_green, pix_blue, pix_alpha,
                  input ready);
  modport sink (input valid, opcode, col, row, pix_red, pix_green, pix_blue, pix_alpha,
                output ready);
endinterface

interface mir_out_if import mir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   out_red;
  logic [PIX_W-1:0]   out_green;
  logic [PIX_W-1:0]   out_blue;
  logic [PIX_W-1:0]   out_alpha;
  logic [FAULT_W-1:0] fault;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, fault, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, fault, output ready);
endinterface

@@ rtl/core/mitchell_image_resampler.sv @@
// mitchell-netravali (b = c = 1/3) image resampler, top level
// depends on mir_pkg, mir_if and mitchell_image_resampler_assert.svh
//
//   channel   dir   payload                                   transfer
//   in_i      in    opcode, col, row, pix_red/green/blue/alpha  valid & ready
//   out_o     out   out_red/green/blue/alpha, fault             valid & ready
//   cfg       in    cfg_idx_i, cfg_data_i                       cfg_we_i
//
// a load writes one word of the image store.
// a compute runs the shared restoring divider for the scale of each axis and for one
// kernel argument per tap inside the support, then one store read per 2d tap, then
// the divider again for one quotient per channel that is not clamped; nx, ny reach 16
// at a ratio of 4. a ratio fault goes from idle straight to the done state.
// the store has no reset; reset clears the sequencer and valids and sets the config registers to their defaults.
// input is taken only when the sequencer is idle; a result waits in the output
// register and a new item may be taken while it waits.
`include "mitchell_image_resampler_assert.svh"
module mitchell_image_resampler import mir_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int MAX_RATIO = MAX_RATIO_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mir_in_if.sink           in_i,
  mir_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_data_i
);

  localparam int TAP_CAP = 4 * MAX_RATIO + 2;
  localparam int TIW     = $clog2(TAP_CAP);
  localparam int NW      = $clog2(TAP_CAP + 1);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADW     = $clog2(DEPTH);
  localparam int DIM_CAP = (MAX_DIM < 256) ? MAX_DIM : 256;
  localparam int RPW     = DIM_W + $clog2(MAX_RATIO + 1);
  localparam int RECIP9  = (1 << 24) / 9;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_AX_START = 16'h0002,
    S_DIV      = 16'h0004,
    S_AX_SET   = 16'h0008,
    S_AX_RANGE = 16'h0010,
    S_TAP      = 16'h0020,
    S_KER1     = 16'h0040,
    S_KER2     = 16'h0080,
    S_KER3     = 16'h0100,
    S_KER4     = 16'h0200,
    S_TOTAL    = 16'h0400,
    S_CHECK    = 16'h0800,
    S_ACC      = 16'h1000,
    S_DRAIN    = 16'h2000,
    S_FIN      = 16'h4000,
    S_DONE     = 16'h8000
  } state_e;

  typedef enum logic [1:0] {
    DIV_SCALE = 2'd0,
    DIV_TAP   = 2'd1,
    DIV_FINAL = 2'd2
  } div_kind_e;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_CAP)) begin
      r = DIM_W'(DIM_CAP);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // control and config state
  state_e           state_q;
  div_kind_e        div_kind_q;
  logic [DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic             axis_q;
  logic [COORD_W-1:0] col_q, row_q;

  // per axis working registers
  logic [24:0]        scale_q;
  logic [24:0]        m_q;
  logic [25:0]        sup_q;
  logic signed [34:0] c_q;
  logic signed [20:0] i_q, last_q;
  logic [NW-1:0]      n_q, nx_q, ny_q;
  logic signed [20:0] wsum_q, wsx_q, wsy_q;

  // shared restoring divider
  logic [51:0] rem_q, dsh_q;
  logic [24:0] quo_q;
  logic [4:0]  cnt_q;

  // kernel evaluation
  logic [16:0] u_q;
  logic [33:0] u2_q;
  logic [50:0] u3_q;
  logic [19:0] yo_q;

  // tap tables
  logic signed [15:0] wx_q [TAP_CAP];
  logic signed [15:0] wy_q [TAP_CAP];
  logic [7:0]         ix_q [TAP_CAP];
  logic [7:0]         iy_q [TAP_CAP];

  // accumulation
  logic [NW-1:0]      a_q, b_q;
  logic signed [41:0] total_q;
  logic               neg_q;
  logic [40:0]        tabs_q;
  logic               p1_v_q, p2_v_q;
  logic signed [31:0] p1_w_q;
  logic signed [39:0] p2_prod_q [4];
  logic signed [47:0] sum_q [4];
  logic [2:0]         k_q;

  // result staging and output register
  logic [PIX_W-1:0] res_q [4];
  fault_e           res_fault_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_red_q, out_green_q, out_blue_q, out_alpha_q;
  fault_e           out_fault_q;

  // image store
  logic [31:0]    image_store_q [DEPTH];
  logic [31:0]    image_rd_q;
  logic           mem_we;
  logic [ADW-1:0] wr_addr, rd_addr;
  logic [31:0]    wr_data;

  // effective dimensions and ratio check
  logic [DIM_W-1:0] sw, sh, tw, th;
  logic             ratio_bad;
  assign sw = eff_dim(src_w_q);
  assign sh = eff_dim(src_h_q);
  assign tw = eff_dim(dst_w_q);
  assign th = eff_dim(dst_h_q);
  assign ratio_bad = (RPW'(sw) > RPW'(tw) * RPW'(MAX_RATIO)) ||
                     (RPW'(sh) > RPW'(th) * RPW'(MAX_RATIO));

  logic in_acc;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // axis selection
  logic [DIM_W-1:0]   axis_src, axis_dst;
  logic [COORD_W-1:0] axis_d;
  assign axis_src = axis_q ? sh : sw;
  assign axis_dst = axis_q ? th : tw;
  assign axis_d   = axis_q ? row_q : col_q;

  // tap centre, range and distance
  logic [33:0]        cprod;
  logic signed [34:0] c_new;
  logic [24:0]        m_new;
  logic signed [35:0] lo_s, hi_s, lo_sh, hi_sh;
  logic signed [37:0] tdiff;
  logic [36:0]        t_abs;
  logic               t_far, axis_done;
  logic signed [20:0] src_m1;
  logic [7:0]         tap_idx;
  assign cprod = 34'({axis_d, 1'b1}) * 34'(scale_q);
  assign c_new = $signed(35'(cprod >> 1)) - 35'sd32768;
  assign m_new = (scale_q > 25'd65536) ? scale_q : 25'd65536;
  assign lo_s  = $signed({10'b0, sup_q}) - 36'(c_q);
  assign hi_s  = 36'(c_q) + $signed({10'b0, sup_q});
  assign lo_sh = lo_s >>> 16;
  assign hi_sh = hi_s >>> 16;
  assign tdiff = 38'(c_q) - (38'(i_q) <<< 16);
  assign t_abs = (tdiff < 0) ? 37'(-tdiff) : 37'(tdiff);
  assign t_far = t_abs >= 37'(sup_q);
  assign axis_done = (i_q > last_q) || (n_q == NW'(TAP_CAP));
  assign src_m1 = $signed({12'b0, axis_src - 9'd1});
  always_comb begin
    if (i_q < 0) begin
      tap_idx = 8'd0;
    end else if (i_q > src_m1) begin
      tap_idx = src_m1[7:0];
    end else begin
      tap_idx = i_q[7:0];
    end
  end

  // divider step
  logic        div_ge;
  logic [51:0] rem_step;
  logic [24:0] quo_next;
  assign div_ge   = rem_q >= dsh_q;
  assign rem_step = div_ge ? rem_q - dsh_q : rem_q;
  assign quo_next = {quo_q[23:0], div_ge};

  // kernel numerator, then division by 9 * 2^34 rounded half up via a reciprocal
  logic signed [59:0] k_u1, k_u2s, k_u3, k_num, k_x, k_y;
  logic [40:0]        k_prod;
  logic [16:0]        k_qe, k_qc;
  logic [20:0]        k_rem;
  logic signed [15:0] w_ker;
  always_comb begin
    k_u1  = $signed(60'(u_q));
    k_u2s = $signed(60'(u2_q)) <<< 16;
    k_u3  = $signed(60'(u3_q));
    if (u_q < 17'd65536) begin
      k_num = 60'sd21 * k_u3 - 60'sd36 * k_u2s + (60'sd16 <<< 48);
    end else begin
      k_num = -(60'sd7 * k_u3) + 60'sd36 * k_u2s - 60'sd60 * (k_u1 <<< 32)
              + (60'sd32 <<< 48);
    end
    k_x = k_num + (60'sd9 <<< 33);
    k_y = (k_x >>> 34) + 60'sd589824;
  end
  assign k_prod = 41'(yo_q) * 41'(RECIP9);
  assign k_qe   = 17'(k_prod >> 24);
  assign k_rem  = 21'(yo_q) - 21'(k_qe) * 21'd9;
  assign k_qc   = (k_rem >= 21'd9) ? k_qe + 17'd1 : k_qe;
  assign w_ker  = $signed(k_qc[15:0]);

  // tap table write
  logic               tap_we;
  logic signed [15:0] tap_w;
  assign tap_we = ((state_q == S_TAP) && !axis_done && t_far) || (state_q == S_KER4);
  assign tap_w  = (state_q == S_KER4) ? w_ker : 16'sd0;

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      if (!axis_q) begin
        wx_q[n_q[TIW-1:0]] <= tap_w;
        ix_q[n_q[TIW-1:0]] <= tap_idx;
      end else begin
        wy_q[n_q[TIW-1:0]] <= tap_w;
        iy_q[n_q[TIW-1:0]] <= tap_idx;
      end
    end
  end

  // final per channel numerator and limit
  logic signed [47:0] s_sel;
  logic signed [50:0] f_num, f_lim;
  assign s_sel = neg_q ? -sum_q[k_q[1:0]] : sum_q[k_q[1:0]];
  assign f_num = (51'(s_sel) <<< 1) + $signed({10'b0, tabs_q});
  assign f_lim = $signed({1'b0, tabs_q, 9'b0});

  // image store port
  logic acc_issue, acc_last;
  assign mem_we  = in_acc && (in_i.opcode == OP_LOAD) &&
                   (int'(in_i.col) < MAX_DIM) && (int'(in_i.row) < MAX_DIM);
  assign wr_addr = ADW'(in_i.row) * ADW'(MAX_DIM) + ADW'(in_i.col);
  assign wr_data = {in_i.pix_alpha, in_i.pix_red, in_i.pix_green, in_i.pix_blue};
  assign rd_addr = ADW'(iy_q[b_q[TIW-1:0]]) * ADW'(MAX_DIM) + ADW'(ix_q[a_q[TIW-1:0]]);
  assign acc_issue = (state_q == S_ACC);
  assign acc_last  = (a_q == nx_q - NW'(1)) && (b_q == ny_q - NW'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      image_store_q[wr_addr] <= wr_data;
    end
    image_rd_q <= image_store_q[rd_addr];
  end

  // accumulation pipeline: weight product, channel products, sums
  logic [7:0] rd_ch [4];
  assign rd_ch[0] = image_rd_q[23:16];
  assign rd_ch[1] = image_rd_q[15:8];
  assign rd_ch[2] = image_rd_q[7:0];
  assign rd_ch[3] = image_rd_q[31:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      p1_v_q <= acc_issue;
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_issue) begin
      p1_w_q <= 32'(wx_q[a_q[TIW-1:0]]) * 32'(wy_q[b_q[TIW-1:0]]);
    end
    for (int ch = 0; ch < 4; ch++) begin
      if (p1_v_q) begin
        p2_prod_q[ch] <= 40'(p1_w_q) * $signed({32'b0, rd_ch[ch]});
      end
      if (state_q == S_CHECK) begin
        sum_q[ch] <= '0;
      end else if (p2_v_q) begin
        sum_q[ch] <= sum_q[ch] + 48'(p2_prod_q[ch]);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_kind_q  <= DIV_SCALE;
      src_w_q     <= SRC_W_RST;
      src_h_q     <= SRC_H_RST;
      dst_w_q     <= DST_W_RST;
      dst_h_q     <= DST_H_RST;
      axis_q      <= 1'b0;
      n_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // config writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SOURCE_WIDTH:  src_w_q <= cfg_data_i;
          REG_SOURCE_HEIGHT: src_h_q <= cfg_data_i;
          REG_TARGET_WIDTH:  dst_w_q <= cfg_data_i;
          REG_TARGET_HEIGHT: dst_h_q <= cfg_data_i;
          default: ;
        endcase
      end

      // output transfer, unless a new result is loaded in the same cycle
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc && (in_i.opcode == OP_COMPUTE)) begin
            col_q <= in_i.col;
            row_q <= in_i.row;
            for (int ch = 0; ch < 4; ch++) begin
              res_q[ch] <= '0;
            end
            if (ratio_bad) begin
              res_fault_q <= FAULT_RATIO;
              state_q     <= S_DONE;
            end else begin
              res_fault_q <= FAULT_NONE;
              axis_q      <= 1'b0;
              state_q     <= S_AX_START;
            end
          end
        end

        // scale = floor(src * 2^16 / dst)
        S_AX_START: begin
          rem_q      <= 52'(axis_src) << 16;
          dsh_q      <= 52'(axis_dst) << 24;
          quo_q      <= '0;
          cnt_q      <= 5'd25;
          div_kind_q <= DIV_SCALE;
          state_q    <= S_DIV;
        end

        S_DIV: begin
          rem_q <= rem_step;
          dsh_q <= dsh_q >> 1;
          quo_q <= quo_next;
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd1) begin
            case (div_kind_q)
              DIV_SCALE: begin
                scale_q <= quo_next;
                state_q <= S_AX_SET;
              end
              DIV_TAP: begin
                u_q     <= quo_next[16:0];
                state_q <= S_KER1;
              end
              DIV_FINAL: begin
                res_q[k_q[1:0]] <= quo_next[7:0];
                k_q     <= k_q + 3'd1;
                state_q <= S_FIN;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end

        S_AX_SET: begin
          c_q     <= c_new;
          m_q     <= m_new;
          sup_q   <= {m_new, 1'b0};
          state_q <= S_AX_RANGE;
        end

        S_AX_RANGE: begin
          i_q     <= 21'(-lo_sh);
          last_q  <= 21'(hi_sh);
          n_q     <= '0;
          wsum_q  <= '0;
          state_q <= S_TAP;
        end

        S_TAP: begin
          if (axis_done) begin
            if (!axis_q) begin
              nx_q    <= n_q;
              wsx_q   <= wsum_q;
              axis_q  <= 1'b1;
              state_q <= S_AX_START;
            end else begin
              ny_q    <= n_q;
              wsy_q   <= wsum_q;
              state_q <= S_TOTAL;
            end
          end else if (t_far) begin
            // outside the support: weight zero
            n_q <= n_q + NW'(1);
            i_q <= i_q + 21'sd1;
          end else begin
            rem_q      <= 52'(t_abs) << 16;
            dsh_q      <= 52'(m_q) << 16;
            quo_q      <= '0;
            cnt_q      <= 5'd17;
            div_kind_q <= DIV_TAP;
            state_q    <= S_DIV;
          end
        end

        S_KER1: begin
          u2_q    <= 34'(u_q) * 34'(u_q);
          state_q <= S_KER2;
        end

        S_KER2: begin
          u3_q    <= 51'(u2_q) * 51'(u_q);
          state_q <= S_KER3;
        end

        S_KER3: begin
          yo_q    <= 20'(k_y);
          state_q <= S_KER4;
        end

        S_KER4: begin
          wsum_q  <= wsum_q + 21'(w_ker);
          n_q     <= n_q + NW'(1);
          i_q     <= i_q + 21'sd1;
          state_q <= S_TAP;
        end

        S_TOTAL: begin
          total_q <= 42'(wsx_q) * 42'(wsy_q);
          state_q <= S_CHECK;
        end

        S_CHECK: begin
          if (total_q == '0) begin
            res_fault_q <= FAULT_WSUM;
            state_q     <= S_DONE;
          end else begin
            neg_q   <= total_q < 0;
            tabs_q  <= (total_q < 0) ? 41'(-total_q) : 41'(total_q);
            a_q     <= '0;
            b_q     <= '0;
            state_q <= S_ACC;
          end
        end

        // one store read per 2d tap
        S_ACC: begin
          if (acc_last) begin
            state_q <= S_DRAIN;
          end else if (a_q == nx_q - NW'(1)) begin
            a_q <= '0;
            b_q <= b_q + NW'(1);
          end else begin
            a_q <= a_q + NW'(1);
          end
          k_q <= '0;
        end

        S_DRAIN: begin
          if (!p1_v_q && !p2_v_q) begin
            state_q <= S_FIN;
          end
        end

        // round half up and clamp, dividing only when inside 0..255
        S_FIN: begin
          if (k_q == 3'd4) begin
            state_q <= S_DONE;
          end else if (f_num < 0) begin
            res_q[k_q[1:0]] <= '0;
            k_q <= k_q + 3'd1;
          end else if (f_num >= f_lim) begin
            res_q[k_q[1:0]] <= '1;
            k_q <= k_q + 3'd1;
          end else begin
            rem_q      <= 52'(f_num);
            dsh_q      <= 52'(tabs_q) << 8;
            quo_q      <= '0;
            cnt_q      <= 5'd8;
            div_kind_q <= DIV_FINAL;
            state_q    <= S_DIV;
          end
        end

        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_red_q   <= res_q[0];
            out_green_q <= res_q[1];
            out_blue_q  <= res_q[2];
            out_alpha_q <= res_q[3];
            out_fault_q <= res_fault_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_red   = out_red_q;
  assign out_o.out_green = out_green_q;
  assign out_o.out_blue  = out_blue_q;
  assign out_o.out_alpha = out_alpha_q;
  assign out_o.fault     = out_fault_q;

  // checks
  `MIR_ASSERT_ALW(a_state_onehot, clk_i, rst_ni, $onehot(state_q), "sequencer state not one-hot")
  `MIR_ASSERT_IMP(a_fin_drained, clk_i, rst_ni, state_q == S_FIN, !p1_v_q && !p2_v_q, "rounding started before accumulation drained")
  `MIR_ASSERT_IMP(a_ratio_zero, clk_i, rst_ni, out_o.valid && out_o.fault == FAULT_RATIO, out_o.out_red == '0 && out_o.out_green == '0 && out_o.out_blue == '0 && out_o.out_alpha == '0, "ratio fault with nonzero channels")
  `MIR_ASSERT_NXT(a_compute_busy, clk_i, rst_ni, in_acc && in_i.opcode == OP_COMPUTE, state_q != S_IDLE, "compute transfer did not start the sequencer")

endmodule

@@ tb/mir_resampler_checker.sv @@
// checker for the mitchell image resampler: watches both channels and the config port,
// keeps its own image store and predicts each compute; depends on mir_pkg and mir_if
`timescale 1ns / 1ps
module mir_resampler_checker import mir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  mir_in_if                in_mon,
  mir_out_if               out_mon,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               outstanding_o,
  output int               results_seen_o
);

  localparam longint ONE_Q16 = 64'sd65536;
  localparam int     TAPS    = 4 * MAX_RATIO_DEF + 2;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    fault_e           fault;
  } pixel_result_t;

  logic [31:0]      shadow_img [MAX_DIM_DEF*MAX_DIM_DEF];
  logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h;
  pixel_result_t    pending_px[$];
  int               fails;
  int               seen;

  assign fail_count_o   = fails;
  assign outstanding_o  = pending_px.size();
  assign results_seen_o = seen;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clamp_dim(logic [DIM_W-1:0] v);
    longint d;
    d = longint'(v);
    if (d < 1) d = 1;
    if (d > 256) d = 256;
    return d;
  endfunction

  // mitchell kernel, q16 argument to q15 weight, rounded half up
  function automatic longint mitchell_q15(longint u);
    longint u2, u3, num;
    if (u >= 2 * ONE_Q16) return 0;
    u2 = u * u;
    u3 = u2 * u;
    if (u < ONE_Q16) num = 21 * u3 - 36 * u2 * ONE_Q16 + 16 * (64'sd1 << 48);
    else num = -7 * u3 + 36 * u2 * ONE_Q16 - 60 * u * (64'sd1 << 32) + 32 * (64'sd1 << 48);
    return fdiv(num + 9 * (64'sd1 << 33), 18 * (64'sd1 << 33));
  endfunction

  // taps of one axis: clamped indices, weights and their sum
  function automatic int axis_weights(longint d, longint src, longint dst,
                                      output longint idx [TAPS], output longint wt [TAPS],
                                      output longint wsum);
    longint scale, m, c, sup, first, last, i, t;
    int n;
    scale = (src * ONE_Q16) / dst;
    m = (scale > ONE_Q16) ? scale : ONE_Q16;
    c = (((2 * d + 1) * scale) >>> 1) - 32768;
    sup = 2 * m;
    first = -fdiv(sup - c, ONE_Q16);
    last = fdiv(c + sup, ONE_Q16);
    n = 0;
    wsum = 0;
    for (i = first; i <= last && n < TAPS; i++) begin
      t = c - i * ONE_Q16;
      if (t < 0) t = -t;
      wt[n] = mitchell_q15((t * ONE_Q16) / m);
      wsum += wt[n];
      idx[n] = (i < 0) ? 0 : ((i > src - 1) ? src - 1 : i);
      n++;
    end
    return n;
  endfunction

  function automatic pixel_result_t resample_pixel(logic [COORD_W-1:0] col,
                                                   logic [COORD_W-1:0] row);
    pixel_result_t r;
    longint sw, sh, tw, th, wsx, wsy, total, prod, v;
    longint ix [TAPS], iy [TAPS], wx [TAPS], wy [TAPS];
    longint acc [4];
    logic [31:0] p;
    int nx, ny;
    r = '0;
    r.fault = FAULT_NONE;
    sw = clamp_dim(src_w);
    sh = clamp_dim(src_h);
    tw = clamp_dim(dst_w);
    th = clamp_dim(dst_h);
    if (sw > MAX_RATIO_DEF * tw || sh > MAX_RATIO_DEF * th) begin
      r.fault = FAULT_RATIO;
      return r;
    end
    nx = axis_weights(longint'(col), sw, tw, ix, wx, wsx);
    ny = axis_weights(longint'(row), sh, th, iy, wy, wsy);
    total = wsx * wsy;
    if (total == 0) begin
      r.fault = FAULT_WSUM;
      return r;
    end
    for (int k = 0; k < 4; k++) acc[k] = 0;
    for (int b = 0; b < ny; b++) begin
      for (int a = 0; a < nx; a++) begin
        p = shadow_img[iy[b] * MAX_DIM_DEF + ix[a]];
        prod = wx[a] * wy[b];
        acc[0] += prod * longint'(p[23:16]);
        acc[1] += prod * longint'(p[15:8]);
        acc[2] += prod * longint'(p[7:0]);
        acc[3] += prod * longint'(p[31:24]);
      end
    end
    if (total < 0) begin
      total = -total;
      for (int k = 0; k < 4; k++) acc[k] = -acc[k];
    end
    for (int k = 0; k < 4; k++) begin
      v = fdiv(2 * acc[k] + total, 2 * total);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      acc[k] = v;
    end
    r.red   = acc[0][7:0];
    r.green = acc[1][7:0];
    r.blue  = acc[2][7:0];
    r.alpha = acc[3][7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] resampler error: %s got %0d want %0d", $realtime, what, got, want);
    fails++;
  endtask

  // config shadow, image shadow on each load and prediction on each compute transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w <= SRC_W_RST;
      src_h <= SRC_H_RST;
      dst_w <= DST_W_RST;
      dst_h <= DST_H_RST;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_SOURCE_WIDTH:  src_w <= cfg_data_i;
          REG_SOURCE_HEIGHT: src_h <= cfg_data_i;
          REG_TARGET_WIDTH:  dst_w <= cfg_data_i;
          default:           dst_h <= cfg_data_i;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (opcode_e'(in_mon.opcode) == OP_LOAD)
          shadow_img[{in_mon.row, in_mon.col}] =
            {in_mon.pix_alpha, in_mon.pix_red, in_mon.pix_green, in_mon.pix_blue};
        else
          pending_px.push_back(resample_pixel(in_mon.col, in_mon.row));
      end
    end
  end

  // compare each output transfer with the oldest prediction
  initial begin
    fails = 0;
    seen = 0;
  end

  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      seen++;
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected result, fault", out_mon.fault, 0);
      end else begin
        want = pending_px.pop_front();
        if (out_mon.fault !== want.fault) report_mismatch("fault", out_mon.fault, want.fault);
        if (out_mon.out_red !== want.red) report_mismatch("red", out_mon.out_red, want.red);
        if (out_mon.out_green !== want.green)
          report_mismatch("green", out_mon.out_green, want.green);
        if (out_mon.out_blue !== want.blue) report_mismatch("blue", out_mon.out_blue, want.blue);
        if (out_mon.out_alpha !== want.alpha)
          report_mismatch("alpha", out_mon.out_alpha, want.alpha);
      end
    end
  end

endmodule

@@ tb/tb_mitchell_image_resampler.sv @@
// testbench top for the mitchell image resampler: stimulus, config phases and verdict
// depends on mir_pkg, mir_if, the block and mir_resampler_checker
`timescale 1ns / 1ps
module tb_mitchell_image_resampler;
  import mir_pkg::*;

  localparam int DRAIN_CYCLES = 2500;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [DIM_W-1:0] cfg_data;
  int               fail_count, outstanding, results_seen;
  int               tx_idle_pct, rx_idle_pct;
  int               items_sent;
  int               phase_count;
  logic             hold_req, hold_done;
  int               hold_cnt;

  mir_in_if  in_ch ();
  mir_out_if out_ch ();

  mitchell_image_resampler u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  mir_resampler_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .results_seen_o (results_seen)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // long receiver stall, counted in cycles where the sender offers an item
  always @(posedge clk_i) begin
    if (hold_req && !hold_done && in_ch.valid) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 3000) hold_done <= 1'b1;
    end
  end

  // receiver ready with random stalls
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  // offer one item, with a random gap first, and wait for its transfer
  task automatic send_item(opcode_e op, logic [7:0] col, logic [7:0] row, logic [31:0] argb);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.opcode    <= op;
    in_ch.col       <= col;
    in_ch.row       <= row;
    in_ch.pix_alpha <= argb[31:24];
    in_ch.pix_red   <= argb[23:16];
    in_ch.pix_green <= argb[15:8];
    in_ch.pix_blue  <= argb[7:0];
    in_ch.valid     <= 1'b1;
    // ready only moves at a rising edge, so sample it between edges
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
    if (items_sent > 270) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end else if (items_sent > 130) begin
      tx_idle_pct = 47;
      rx_idle_pct = 36;
    end
  endtask

  // stop offering until every prediction has come back, then let the block settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DIM_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // one setting: write the registers, fill the source image, then mixed traffic
  task automatic run_phase(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                           logic [DIM_W-1:0] tw, logic [DIM_W-1:0] th, int n_rand,
                           bit directed);
    int esw, esh, etw, eth;
    logic [7:0] c, r;
    drain_results();
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
    write_reg(REG_TARGET_WIDTH, tw);
    write_reg(REG_TARGET_HEIGHT, th);
    phase_count++;
    esw = clamp_dim(sw);
    esh = clamp_dim(sh);
    etw = clamp_dim(tw);
    eth = clamp_dim(th);
    for (int y = 0; y < esh; y++)
      for (int x = 0; x < esw; x++)
        send_item(OP_LOAD, x[7:0], y[7:0], $urandom);
    if (directed) begin
      // extreme pixel values, extreme coordinates, outside the target
      send_item(OP_LOAD, 8'd0, 8'd0, 32'hFFFF_FFFF);
      send_item(OP_LOAD, 8'd1, 8'd1, 32'h0000_0000);
      send_item(OP_COMPUTE, 8'd0, 8'd0, 32'h0);
      send_item(OP_COMPUTE, 8'd255, 8'd255, 32'hFFFF_FFFF);
      send_item(OP_COMPUTE, 8'd0, 8'd255, 32'h0);
      send_item(OP_COMPUTE, 8'd255, 8'd0, 32'h0);
      send_item(OP_COMPUTE, 8'd3, 8'd2, 32'h0);
      send_item(OP_LOAD, 8'd2, 8'd3, 32'hFF00_FF00);
      send_item(OP_LOAD, 8'd3, 8'd2, 32'h00FF_00FF);
      send_item(OP_COMPUTE, 8'd5, 8'd6, 32'h0);
      send_item(OP_COMPUTE, 8'd7, 8'd7, 32'h0);
    end
    for (int k = 0; k < n_rand; k++) begin
      if ($urandom_range(99) < 25) begin
        send_item(OP_LOAD, 8'($urandom_range(esw - 1)), 8'($urandom_range(esh - 1)),
                  $urandom);
      end else begin
        if ($urandom_range(9) < 8) begin
          c = 8'($urandom_range(etw - 1));
          r = 8'($urandom_range(eth - 1));
        end else begin
          c = 8'($urandom);
          r = 8'($urandom);
        end
        send_item(OP_COMPUTE, c, r, $urandom);
      end
    end
  endtask

  // watchdog
  initial begin
    #50ms;
    $display("mitchell_image_resampler: mismatch");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_SOURCE_WIDTH;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_LOAD;
    in_ch.col    = '0;
    in_ch.row    = '0;
    in_ch.pix_red   = '0;
    in_ch.pix_green = '0;
    in_ch.pix_blue  = '0;
    in_ch.pix_alpha = '0;
    out_ch.ready = 1'b0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    hold_cnt     = 0;
    tx_idle_pct  = 36;
    rx_idle_pct  = 47;
    items_sent   = 0;
    phase_count  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_phase(9'd4, 9'd4, 9'd8, 9'd8, 20, 1'b1);
    // receiver stalls for a long stretch while the sender keeps going
    drain_results();
    hold_req <= 1'b1;
    run_phase(9'd8, 9'd8, 9'd2, 9'd2, 20, 1'b0);
    run_phase(9'd1, 9'd1, 9'd1, 9'd1, 15, 1'b0);
    run_phase(9'd32, 9'd1, 9'd8, 9'd1, 10, 1'b0);
    run_phase(9'd1, 9'd24, 9'd1, 9'd6, 10, 1'b0);
    run_phase(9'd0, 9'd3, 9'd511, 9'd2, 25, 1'b0);
    run_phase(9'd5, 9'd9, 9'd2, 9'd2, 15, 1'b0);
    run_phase(9'd5, 9'd7, 9'd3, 9'd5, 20, 1'b0);
    for (int p = 0; p < 2; p++)
      run_phase(9'($urandom_range(8, 1)), 9'($urandom_range(8, 1)),
                9'($urandom_range(16, 1)), 9'($urandom_range(16, 1)), 15, 1'b0);
    drain_results();

    $display("run covered %0d config settings, %0d input transfers, %0d results checked",
             phase_count, items_sent, results_seen);
    if (fail_count == 0) begin
      $display("mitchell_image_resampler: match");
    end else begin
      $display("mitchell_image_resampler: mismatch");
    end
    $finish;
  end

endmodule
